@@ design/plist_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// plist_pkg - shared types and codes for the positional list engine
// Command and status codes, controller states and the controller to
// datapath command bundle.
// ============================================================================
package plist_pkg;

    localparam int DATA_W  = 32;
    localparam int POS_W   = 8;
    localparam int COUNT_W = 5;

    typedef enum logic [2:0] {
        CMD_APPEND    = 3'd0,
        CMD_PREPEND   = 3'd1,
        CMD_INSERT    = 3'd2,
        CMD_LENGTH    = 3'd3,
        CMD_DISPLAY   = 3'd4,
        CMD_DEL_FIRST = 3'd5,
        CMD_DEL_LAST  = 3'd6,
        CMD_DEL_POS   = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_UP_RD    = 7'b0000010,
        S_UP_WR    = 7'b0000100,
        S_DN_RD    = 7'b0001000,
        S_DN_WR    = 7'b0010000,
        S_DISP_RD  = 7'b0100000,
        S_DISP_OUT = 7'b1000000
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    load_val;   // capture request value
        logic    rd_en;      // registered store read
        logic    wr_en;      // store write at wr_addr
        logic    wr_sel_val; // write request value (else read data)
        logic    cnt_inc;
        logic    cnt_dec;
        logic    emit;       // launch one result
        logic    emit_elem;  // result element from read data (else zero)
        logic    emit_last;
        status_t emit_status;
    } dp_cmd_t;

endpackage

@@ design/plist_dp.sv @@
`timescale 1ns / 1ps
// ============================================================================
// plist_dp - element store, length counter and result registers
// Executes controller commands; one store read and one write per cycle.
// ============================================================================
module plist_dp #(
    parameter int CAPACITY = 16,
    parameter int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    parameter int CW = $clog2(CAPACITY + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  plist_pkg::dp_cmd_t                  cmd,
    input  logic [AW-1:0]                       rd_addr,
    input  logic [AW-1:0]                       wr_addr,
    input  logic signed [plist_pkg::DATA_W-1:0] value,
    output logic [CW-1:0]                       cnt,
    output logic                                done,
    output logic [1:0]                          status,
    output logic signed [plist_pkg::DATA_W-1:0] element,
    output logic [plist_pkg::COUNT_W-1:0]       count,
    output logic                                last
);
    import plist_pkg::*;

    logic signed [DATA_W-1:0] mem [CAPACITY];
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] rdata_reg;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic                     done_reg;
    logic [1:0]               status_reg;
    logic signed [DATA_W-1:0] element_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic                     last_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    // store: no reset, only entries below the count are read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= cmd.wr_sel_val ? value_reg : rdata_reg;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (cmd.load_val)
        begin
            value_reg <= value;
        end
        if (cmd.emit)
        begin
            status_reg  <= cmd.emit_status;
            element_reg <= cmd.emit_elem ? rdata_reg : '0;
            count_reg   <= COUNT_W'(cnt_reg);
            last_reg    <= cmd.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= cmd.emit;
        end
    end

    assign cnt     = cnt_reg;
    assign done    = done_reg;
    assign status  = status_reg;
    assign element = element_reg;
    assign count   = count_reg;
    assign last    = last_reg;

endmodule

@@ design/plist_ctrl.sv @@
`timescale 1ns / 1ps
// ============================================================================
// plist_ctrl - command sequencer for the positional list engine
// Decodes a request, checks it against the count and walks the store.
// ============================================================================
module plist_ctrl #(
    parameter int CAPACITY = 16,
    parameter int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    parameter int CW = $clog2(CAPACITY + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [2:0]                   command,
    input  logic [plist_pkg::POS_W-1:0]  position,
    input  logic [CW-1:0]                cnt,
    output logic                         busy,
    output plist_pkg::dp_cmd_t           cmd,
    output logic [AW-1:0]                rd_addr,
    output logic [AW-1:0]                wr_addr
);
    import plist_pkg::*;

    localparam int EW = ((CW > POS_W) ? CW : POS_W) + 1;

    state_t        state_reg, state_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] idx_reg, idx_next;
    status_t       st_reg, st_next;
    logic          fin_reg, fin_next;   // single closing result pending

    logic [EW-1:0] pos_ext, cnt_ext;
    logic          full, empty, ins_ok, del_ok, ptr1_end;

    assign pos_ext  = EW'(position);
    assign cnt_ext  = EW'(cnt);
    assign full     = (cnt == CW'(CAPACITY));
    assign empty    = (cnt == '0);
    assign ins_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext + EW'(1));
    assign del_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign ptr1_end = ((CW'(ptr_reg) + CW'(1)) >= cnt);

    assign busy    = (state_reg != S_IDLE) || fin_reg;
    assign wr_addr = ptr_reg;

    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        idx_next   = idx_reg;
        st_next    = st_reg;
        fin_next   = 1'b0;
        cmd        = '0;
        rd_addr    = ptr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (fin_reg)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_last   = 1'b1;
                    cmd.emit_status = st_reg;
                end
                else if (start)
                begin
                    cmd.load_val = 1'b1;
                    st_next      = ST_OK;
                    ptr_next     = AW'(cnt);
                    unique case (cmd_t'(command))
                        CMD_APPEND, CMD_PREPEND, CMD_INSERT:
                        begin
                            if (full)
                            begin
                                st_next  = ST_FULL;
                                fin_next = 1'b1;
                            end
                            else if (cmd_t'(command) == CMD_APPEND)
                            begin
                                idx_next   = AW'(cnt);
                                state_next = S_UP_RD;
                            end
                            else if (cmd_t'(command) == CMD_PREPEND)
                            begin
                                idx_next   = '0;
                                state_next = S_UP_RD;
                            end
                            else if (!ins_ok)
                            begin
                                st_next  = ST_BADPOS;
                                fin_next = 1'b1;
                            end
                            else
                            begin
                                idx_next   = AW'(pos_ext - EW'(1));
                                state_next = S_UP_RD;
                            end
                        end
                        CMD_LENGTH:
                        begin
                            fin_next = 1'b1;
                        end
                        CMD_DISPLAY:
                        begin
                            if (empty)
                            begin
                                st_next  = ST_EMPTY;
                                fin_next = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = S_DISP_RD;
                            end
                        end
                        CMD_DEL_FIRST:
                        begin
                            if (empty)
                            begin
                                st_next  = ST_EMPTY;
                                fin_next = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = S_DN_RD;
                            end
                        end
                        CMD_DEL_LAST:
                        begin
                            if (empty)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.cnt_dec = 1'b1;
                            end
                            fin_next = 1'b1;
                        end
                        CMD_DEL_POS:
                        begin
                            if (empty)
                            begin
                                st_next  = ST_EMPTY;
                                fin_next = 1'b1;
                            end
                            else if (!del_ok)
                            begin
                                st_next  = ST_BADPOS;
                                fin_next = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = AW'(pos_ext - EW'(1));
                                state_next = S_DN_RD;
                            end
                        end
                        default:
                        begin
                            fin_next = 1'b1;
                        end
                    endcase
                end
            end
            S_UP_RD:
            begin
                if (ptr_reg == idx_reg)
                begin
                    cmd.wr_en      = 1'b1;
                    cmd.wr_sel_val = 1'b1;
                    cmd.cnt_inc    = 1'b1;
                    fin_next       = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    rd_addr    = ptr_reg - AW'(1);
                    cmd.rd_en  = 1'b1;
                    state_next = S_UP_WR;
                end
            end
            S_UP_WR:
            begin
                cmd.wr_en  = 1'b1;
                ptr_next   = ptr_reg - AW'(1);
                state_next = S_UP_RD;
            end
            S_DN_RD:
            begin
                if (ptr1_end)
                begin
                    cmd.cnt_dec = 1'b1;
                    fin_next    = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    rd_addr    = ptr_reg + AW'(1);
                    cmd.rd_en  = 1'b1;
                    state_next = S_DN_WR;
                end
            end
            S_DN_WR:
            begin
                cmd.wr_en  = 1'b1;
                ptr_next   = ptr_reg + AW'(1);
                state_next = S_DN_RD;
            end
            S_DISP_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_DISP_OUT;
            end
            S_DISP_OUT:
            begin
                cmd.emit        = 1'b1;
                cmd.emit_elem   = 1'b1;
                cmd.emit_status = ST_OK;
                cmd.emit_last   = ptr1_end;
                ptr_next        = ptr_reg + AW'(1);
                state_next      = ptr1_end ? S_IDLE : S_DISP_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        idx_reg <= idx_next;
        st_reg  <= st_next;
    end

endmodule

@@ design/positional_list_engine.sv @@
`timescale 1ns / 1ps
// ============================================================================
// positional_list_engine - ordered list of signed 32-bit values
// Append, prepend, positional insert and delete, length and display over
// a store of CAPACITY entries kept in list order.
// ============================================================================
// Sequence: checks-only commands (length, full, empty, bad position, delete
//   last) set a pending closing result on acceptance, launched from idle.
//   Inserts and deletes shift the store one entry at a time through its
//   single read and write port, a read then a write state per moved entry.
//   Display reads each element in S_DISP_RD and launches it in S_DISP_OUT.
// Throughput: one request at a time; busy stays high until the final result
//   is launched. Results cannot be stalled: done marks each for one cycle.
// Reset: asynchronous, active low; the list is empty after reset, the store
//   contents are left as they are.
// ============================================================================
module positional_list_engine #(
    parameter int CAPACITY = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request side
    input  logic                                start,
    output logic                                busy,
    input  logic [2:0]                          command,
    input  logic signed [plist_pkg::DATA_W-1:0] value,
    input  logic [plist_pkg::POS_W-1:0]         position,
    // result side
    output logic                                done,
    output logic [1:0]                          status,
    output logic signed [plist_pkg::DATA_W-1:0] element,
    output logic [plist_pkg::COUNT_W-1:0]       count,
    output logic                                last
);
    import plist_pkg::*;

    // store index width and count width (count must hold CAPACITY itself)
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    dp_cmd_t       dp_cmd;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [CW-1:0] cnt;

    // Sequencer: decodes the request against the current length and steps
    // the shift or readout walk one store access at a time.
    plist_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .command  (command),
        .position (position),
        .cnt      (cnt),
        .busy     (busy),
        .cmd      (dp_cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr)
    );

    // Datapath: element store, length counter and registered result port.
    plist_dp #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (dp_cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .value    (value),
        .cnt      (cnt),
        .done     (done),
        .status   (status),
        .element  (element),
        .count    (count),
        .last     (last)
    );

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// testbench - request/result check of the positional list engine
// Requests go through the start/busy handshake from a queue that is filled
// up front. A list model in the bench predicts every result. Each done strobe
// is compared field by field with the oldest prediction.
// ============================================================================
module testbench;

    import plist_pkg::*;

    localparam int CAPACITY       = 16;
    localparam int HALF_PERIOD    = 6;     // 12 ns clock
    localparam int RESET_CYCLES   = 6;
    localparam int RANDOM_ITEMS   = 114;
    localparam int QUIET_TAIL     = 25;    // requests at the end sent back to back
    localparam int SETTLE_CYCLES  = 60;    // room for stray results after the last one
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with neither a request nor a result

    // One queued request. When hold_for_drain is set, the driver sends it only
    // after every predicted result has arrived.
    typedef struct {
        cmd_t               cmd;
        logic signed [31:0] val;
        logic [7:0]         pos;
        bit                 hold_for_drain;
    } list_request_t;

    typedef struct {
        status_t            status;
        logic signed [31:0] element;
        logic [4:0]         count;
        logic               last;
    } list_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // The block's inputs hold known values from time zero
    logic               start = 1'b0;
    logic [2:0]         command = '0;
    logic signed [31:0] value = '0;
    logic [7:0]         position = '0;

    logic               busy;
    logic               done;
    logic [1:0]         status;
    logic signed [31:0] element;
    logic [4:0]         count;
    logic               last;

    list_request_t      request_queue[$];
    list_result_t       expected_results[$];

    // List as the bench believes it to be
    logic signed [31:0] list_values[CAPACITY];
    int                 list_len = 0;

    // Length tracked while the request queue is built, used only to aim
    // positions at the valid range most of the time
    int                 plan_len = 0;
    bit                 plan_growing = 1'b1;

    int                 error_count = 0;
    int                 requests_accepted = 0;
    int                 idle_left = 0;
    int                 quiet_cycles = 0;

    positional_list_engine #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .command (command),
        .value   (value),
        .position(position),
        .done    (done),
        .status  (status),
        .element (element),
        .count   (count),
        .last    (last)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------------
    // Reporting and list model
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function automatic void push_result(input status_t st, input logic signed [31:0] elem,
                                        input logic is_last);
        list_result_t r;
        r.status  = st;
        r.element = elem;
        r.count   = list_len[4:0];
        r.last    = is_last;
        expected_results.push_back(r);
    endfunction

    // Open a slot at idx by moving later entries up one place
    function automatic void place_value(input int idx, input logic signed [31:0] v);
        for (int i = list_len; i > idx; i--)
            list_values[i] = list_values[i-1];
        list_values[idx] = v;
        list_len++;
    endfunction

    // Close the slot at idx by moving later entries down one place
    function automatic void drop_value(input int idx);
        for (int i = idx; i + 1 < list_len; i++)
            list_values[i] = list_values[i+1];
        list_len--;
    endfunction

    // Applies one request to the list model and queues the results it causes
    function automatic void apply_list_command(input cmd_t cmd, input logic signed [31:0] val,
                                               input logic [7:0] pos);
        status_t st;
        st = ST_OK;
        case (cmd)
            CMD_APPEND, CMD_PREPEND, CMD_INSERT: begin
                // a full list wins over a bad position
                if (list_len >= CAPACITY)
                    st = ST_FULL;
                else if (cmd == CMD_APPEND)
                    place_value(list_len, val);
                else if (cmd == CMD_PREPEND)
                    place_value(0, val);
                else if (pos < 1 || pos > list_len + 1)
                    st = ST_BADPOS;
                else
                    place_value(pos - 1, val);
            end
            CMD_LENGTH: ;
            CMD_DISPLAY: begin
                if (list_len == 0) begin
                    st = ST_EMPTY;
                end else begin
                    // one result per element, last flag on the final one
                    for (int i = 0; i < list_len; i++)
                        push_result(ST_OK, list_values[i], i + 1 == list_len);
                    return;
                end
            end
            CMD_DEL_FIRST: begin
                if (list_len == 0) st = ST_EMPTY;
                else drop_value(0);
            end
            CMD_DEL_LAST: begin
                if (list_len == 0) st = ST_EMPTY;
                else drop_value(list_len - 1);
            end
            default: begin
                if (list_len == 0) st = ST_EMPTY;
                else if (pos < 1 || pos > list_len) st = ST_BADPOS;
                else drop_value(pos - 1);
            end
        endcase
        push_result(st, '0, 1'b1);
    endfunction

    // ------------------------------------------------------------------------
    // Request planning
    // ------------------------------------------------------------------------
    task automatic add_request(input cmd_t c, input logic signed [31:0] v, input logic [7:0] p,
                               input bit hold);
        list_request_t rq;
        rq.cmd = c;
        rq.val = v;
        rq.pos = p;
        rq.hold_for_drain = hold;
        request_queue.push_back(rq);
        // follow the length so later positions can be aimed
        case (c)
            CMD_APPEND, CMD_PREPEND:
                if (plan_len < CAPACITY) plan_len++;
            CMD_INSERT:
                if (plan_len < CAPACITY && p >= 1 && p <= plan_len + 1) plan_len++;
            CMD_DEL_FIRST, CMD_DEL_LAST:
                if (plan_len > 0) plan_len--;
            CMD_DEL_POS:
                if (plan_len > 0 && p >= 1 && p <= plan_len) plan_len--;
            default: ;
        endcase
    endtask

    // Mostly valid positions; the rest anywhere in the 8-bit range
    function automatic logic [7:0] pick_position(input int limit);
        if (limit >= 1 && $urandom_range(0, 9) < 8)
            return 8'($urandom_range(1, limit));
        else if ($urandom_range(0, 3) == 0)
            return 8'd0;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // Grow and shrink phases so the list spends time both near empty and at full
    task automatic add_random_request();
        cmd_t              c;
        int                r;
        logic [7:0]        p;
        r = $urandom_range(0, 99);
        if (plan_growing) begin
            if (r < 25)      c = CMD_APPEND;
            else if (r < 45) c = CMD_PREPEND;
            else if (r < 75) c = CMD_INSERT;
            else if (r < 82) c = CMD_DISPLAY;
            else if (r < 87) c = CMD_LENGTH;
            else if (r < 92) c = CMD_DEL_FIRST;
            else if (r < 96) c = CMD_DEL_LAST;
            else             c = CMD_DEL_POS;
        end else begin
            if (r < 25)      c = CMD_DEL_FIRST;
            else if (r < 45) c = CMD_DEL_LAST;
            else if (r < 75) c = CMD_DEL_POS;
            else if (r < 82) c = CMD_DISPLAY;
            else if (r < 87) c = CMD_LENGTH;
            else if (r < 92) c = CMD_APPEND;
            else if (r < 96) c = CMD_PREPEND;
            else             c = CMD_INSERT;
        end
        p = pick_position(c == CMD_INSERT ? plan_len + 1 : plan_len);
        add_request(c, $urandom, p, $urandom_range(0, 24) == 0);

        // stay at full or empty for a while now and then, to hit those statuses
        if (plan_len >= CAPACITY && $urandom_range(0, 2) != 0)
            plan_growing = 1'b0;
        else if (plan_len == 0 && $urandom_range(0, 2) != 0)
            plan_growing = 1'b1;
        else if ($urandom_range(0, 19) == 0)
            plan_growing = !plan_growing;
    endtask

    // ------------------------------------------------------------------------
    // Driver: one request in flight, presented right after an edge and held
    // until the edge where busy is low.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        bit            idling_allowed;
        list_request_t nxt;
        if (rst_n) begin
            if (start && !busy) begin
                apply_list_command(cmd_t'(command), value, position);
                requests_accepted++;
                // idle gaps come in windows, none in the closing stretch
                idling_allowed = ((requests_accepted / 20) % 3 != 2)
                                 && request_queue.size() > QUIET_TAIL;
                if (idling_allowed && $urandom_range(0, 2) == 0)
                    idle_left = $urandom_range(1, 5);
            end

            if (start && busy) begin
                // keep the request on the ports
            end else if (idle_left > 0) begin
                idle_left--;
                start <= 1'b0;
            end else if (request_queue.size() != 0 &&
                         !(request_queue[0].hold_for_drain && expected_results.size() != 0)) begin
                nxt = request_queue.pop_front();
                start    <= 1'b1;
                command  <= nxt.cmd;
                value    <= nxt.val;
                position <= nxt.pos;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: done marks one result for exactly one cycle
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        list_result_t exp_r;
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status=%0d element=%0d count=%0d",
                                          status, element, count));
            end else begin
                exp_r = expected_results.pop_front();
                if (status !== exp_r.status)
                    report_mismatch($sformatf("status %0d, expected %0d", status, exp_r.status));
                if (element !== exp_r.element)
                    report_mismatch($sformatf("element %0d, expected %0d",
                                              element, exp_r.element));
                if (count !== exp_r.count)
                    report_mismatch($sformatf("count %0d, expected %0d", count, exp_r.count));
                if (last !== exp_r.last)
                    report_mismatch($sformatf("last %0b, expected %0b", last, exp_r.last));
            end
        end
    end

    // Watchdog: a long spell with no request and no result means a hang
    always @(posedge clk) begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", quiet_cycles);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        // Empty list: display and every delete report empty, length reports zero, bad insert positions
        add_request(CMD_DISPLAY,   32'sd0, 8'd0, 1'b0);
        add_request(CMD_LENGTH,    32'sd0, 8'd0, 1'b0);
        add_request(CMD_DEL_FIRST, 32'sd0, 8'd0, 1'b0);
        add_request(CMD_DEL_LAST,  32'sd0, 8'd0, 1'b0);
        add_request(CMD_DEL_POS,   32'sd0, 8'd1, 1'b0);
        add_request(CMD_INSERT,    32'sd5, 8'd0, 1'b0);
        add_request(CMD_INSERT,    32'sd5, 8'd2, 1'b0);
        // Build a small list from value extremes; insert at count+1 appends
        add_request(CMD_INSERT,  32'sh8000_0000, 8'd1, 1'b0);
        add_request(CMD_APPEND,  32'sh7FFF_FFFF, 8'd0, 1'b0);
        add_request(CMD_PREPEND, -32'sd1,        8'd0, 1'b0);
        add_request(CMD_INSERT,  32'sd0,         8'd4, 1'b0);
        add_request(CMD_INSERT,  32'sh5A5A_A5A5, 8'd2, 1'b0);
        add_request(CMD_DISPLAY, 32'sd0,         8'd0, 1'b0);
        // Delete positions out of range, then the last and a middle one
        add_request(CMD_DEL_POS,   32'sd0, 8'd0,   1'b0);
        add_request(CMD_DEL_POS,   32'sd0, 8'd6,   1'b0);
        add_request(CMD_DEL_POS,   32'sd0, 8'd255, 1'b0);
        add_request(CMD_DEL_POS,   32'sd0, 8'd5,   1'b0);
        add_request(CMD_DEL_POS,   32'sd0, 8'd2,   1'b1);
        add_request(CMD_DEL_FIRST, 32'sd0, 8'd0,   1'b0);
        add_request(CMD_DEL_LAST,  32'sd0, 8'd0,   1'b0);
        add_request(CMD_LENGTH,    32'sd0, 8'd0,   1'b0);
        add_request(CMD_DEL_POS,   32'sd0, 8'd1,   1'b0);

        // Fill to capacity with random values, then the full-list cases
        while (plan_len < CAPACITY)
            add_request(CMD_APPEND, $urandom, 8'd0, 1'b0);
        add_request(CMD_APPEND,  32'sd7, 8'd0,  1'b0);
        add_request(CMD_PREPEND, 32'sd7, 8'd0,  1'b0);
        add_request(CMD_INSERT,  32'sd7, 8'd0,  1'b0);   // full wins over bad position
        add_request(CMD_INSERT,  32'sd7, 8'd17, 1'b0);
        add_request(CMD_DISPLAY, 32'sd0, 8'd0,  1'b0);
        add_request(CMD_DEL_POS, 32'sd0, 8'd16, 1'b0);
        add_request(CMD_INSERT,  $urandom, 8'd16, 1'b0);
        add_request(CMD_DISPLAY, 32'sd0, 8'd0,  1'b1);

        for (int n = 0; n < RANDOM_ITEMS; n++)
            add_random_request();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // everything sent, accepted and answered
        while (request_queue.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (request_queue.size() != 0 || expected_results.size() != 0)
            report_mismatch($sformatf("%0d requests unsent, %0d results missing",
                                      request_queue.size(), expected_results.size()));

        if (error_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
